FILE: rtl/core/rhc_pkg.sv
// Package for the RGB to HSV converter: default widths and the hue sector type.
// Used by every module under rtl/core.
`timescale 1ns / 1ps
package rhc_pkg;
    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 6;

    // Hue sector code: which channel was the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;
endpackage

FILE: rtl/core/rgb_to_hsv_converter_top.sv
// Top level of the RGB to HSV converter: front stage, chain of division cells,
// hue finish and output register. Depends on rhc_pkg and rhc_div_cell.
`timescale 1ns / 1ps
// Usage:
//   Input channel i_red/i_green/i_blue with i_valid and o_stall; a beat is
//   taken at a clock edge with i_valid high and o_stall low.
//   Output channel o_hue/o_saturation/o_brightness/o_hue_undefined with
//   o_valid and i_stall; a beat leaves with o_valid high and i_stall low.
//   One pixel enters per clock while o_stall is low. The path holds one
//   front register, one division cell per quotient bit of the longer of the
//   two divisions, and one output register that also takes the hue finish.
//   Throughput is one pixel per clock while the receiver does not stall, set
//   by the chain of division cells, each of which produces one quotient bit
//   per beat.
//   When the receiver stalls while the output register holds a beat, the
//   whole chain holds and o_stall is raised for that cycle; no stage moves
//   until the output beat is taken. Reset empties every stage; nothing else
//   needs clearing.
module rgb_to_hsv_converter_top #(
    parameter int CHANNEL_BITS      = rhc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [CHANNEL_BITS-1:0]        i_red,
    input  logic [CHANNEL_BITS-1:0]        i_green,
    input  logic [CHANNEL_BITS-1:0]        i_blue,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [HUE_FRACTION_BITS+8:0]   o_hue,
    output logic [CHANNEL_BITS-1:0]        o_saturation,
    output logic [CHANNEL_BITS-1:0]        o_brightness,
    output logic                           o_hue_undefined
);
    import rhc_pkg::*;

    localparam int CW    = CHANNEL_BITS;
    localparam int HW    = HUE_FRACTION_BITS + 9;
    localparam int SIXTH = 60 * (1 << HUE_FRACTION_BITS);
    localparam int TURN  = 6 * SIXTH;
    // numerator SIXTH*|diff| fits in HN bits; quotient <= SIXTH
    localparam int HN    = HUE_FRACTION_BITS + 6 + CW;
    localparam int SN    = 2 * CW;
    localparam int NC    = (HN > SN) ? HN : SN;

    // chain is enabled unless output register holds a beat that is stalled
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // front stage: max, min, sector, numerators
    logic [CW-1:0] w_max, w_min, w_chroma, w_diff;
    logic          w_neg;
    t_sector       w_sec;
    logic [HW-1:0] w_base;
    logic [CW:0]   w_sd;

    always_comb begin
        w_max = i_red;
        if (i_green > w_max) w_max = i_green;
        if (i_blue > w_max) w_max = i_blue;
        w_min = i_red;
        if (i_green < w_min) w_min = i_green;
        if (i_blue < w_min) w_min = i_blue;
        w_chroma = w_max - w_min;
        priority if (i_red == w_max) begin
            w_sec = SEC_RED;
            w_sd  = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green == w_max) begin
            w_sec = SEC_GREEN;
            w_sd  = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            w_sec = SEC_BLUE;
            w_sd  = {1'b0, i_red} - {1'b0, i_green};
        end
        w_neg  = w_sd[CW];
        w_diff = w_neg ? CW'(-w_sd) : w_sd[CW-1:0];
        unique case (w_sec)
            SEC_RED:   w_base = '0;
            SEC_GREEN: w_base = HW'(2 * SIXTH);
            SEC_BLUE:  w_base = HW'(4 * SIXTH);
            default:   w_base = '0;
        endcase
    end

    // cell chain storage: index 0 is the front register
    logic          c_valid  [NC+1];
    logic [CW-1:0] c_chroma [NC+1];
    logic [CW-1:0] c_vmax   [NC+1];
    logic [NC-1:0] c_hnum   [NC+1];
    logic [CW:0]   c_hrem   [NC+1];
    logic [NC-1:0] c_snum   [NC+1];
    logic [CW:0]   c_srem   [NC+1];
    logic [HW-1:0] c_base   [NC+1];
    logic          c_neg    [NC+1];
    logic          c_undef  [NC+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_valid[0] <= 1'b0;
        end else if (w_en) begin
            c_valid[0] <= i_valid;
        end
    end

    // front register; both dividends are zero-extended at the top to NC bits
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            c_chroma[0] <= w_chroma;
            c_vmax[0]   <= w_max;
            c_hnum[0]   <= NC'(SIXTH) * NC'(w_diff);
            c_hrem[0]   <= '0;
            c_snum[0]   <= NC'((1 << CW) - 1) * NC'(w_chroma);
            c_srem[0]   <= '0;
            c_base[0]   <= w_base;
            c_neg[0]    <= w_neg;
            c_undef[0]  <= (w_max == '0);
        end
    end

    // the chain: leading zero bits of the shorter dividend leave its
    // remainder at zero, so both quotients land in the low bits
    genvar k;
    generate
        for (k = 0; k < NC; k++) begin : g_cell
            rhc_div_cell #(.CW(CW), .HW(HW), .HN(NC), .SN(NC)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (c_valid[k]),
                .i_chroma(c_chroma[k]),
                .i_vmax  (c_vmax[k]),
                .i_hnum  (c_hnum[k]),
                .i_hrem  (c_hrem[k]),
                .i_snum  (c_snum[k]),
                .i_srem  (c_srem[k]),
                .i_base  (c_base[k]),
                .i_neg   (c_neg[k]),
                .i_undef (c_undef[k]),
                .o_valid (c_valid[k+1]),
                .o_chroma(c_chroma[k+1]),
                .o_vmax  (c_vmax[k+1]),
                .o_hnum  (c_hnum[k+1]),
                .o_hrem  (c_hrem[k+1]),
                .o_snum  (c_snum[k+1]),
                .o_srem  (c_srem[k+1]),
                .o_base  (c_base[k+1]),
                .o_neg   (c_neg[k+1]),
                .o_undef (c_undef[k+1])
            );
        end
    endgenerate

    // hue finish: shifted dividend has become the quotient in its low bits
    logic [HW-1:0] w_q, w_hue;
    logic [HW:0]   w_sum;
    always_comb begin
        w_q = HW'(c_hnum[NC]);
        if (c_neg[NC]) begin
            // floor of a negative quotient: -(q + (rem != 0))
            w_sum = {1'b0, c_base[NC]} - {1'b0, w_q}
                  - (HW+1)'(c_hrem[NC] != '0);
            if (w_sum[HW]) w_sum = w_sum + (HW+1)'(TURN);
        end else begin
            w_sum = {1'b0, c_base[NC]} + {1'b0, w_q};
        end
        w_hue = (c_chroma[NC] == '0) ? '0 : w_sum[HW-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= c_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hue           <= c_undef[NC] ? '0 : w_hue;
            o_saturation    <= c_undef[NC] ? '0 : c_snum[NC][CW-1:0];
            o_brightness    <= c_vmax[NC];
            o_hue_undefined <= c_undef[NC];
        end
    end

    // a stalled output beat holds its place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue))
        else $error("stalled output changed");
    // undefined hue comes only with zero brightness
    a_undef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hue_undefined |-> o_brightness == '0 && o_hue == '0)
        else $error("undefined flag with nonzero fields");
    // hue stays within one turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue < HW'(TURN))
        else $error("hue out of range");
    // stall only while output is full
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without output beat");
endmodule

FILE: rtl/core/rhc_div_cell.sv
// One restoring division cell: produces one quotient bit for the hue and one for
// the saturation quotient per beat, passes the operands on. Depends on rhc_pkg.
`timescale 1ns / 1ps
module rhc_div_cell #(
    parameter int CW = 8,   // channel width
    parameter int HW = 15,  // hue width
    parameter int HN = 15,  // hue dividend width
    parameter int SN = 16   // saturation dividend width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [CW-1:0] i_chroma,
    input  logic [CW-1:0] i_vmax,
    input  logic [HN-1:0] i_hnum,
    input  logic [CW:0]   i_hrem,
    input  logic [SN-1:0] i_snum,
    input  logic [CW:0]   i_srem,
    input  logic [HW-1:0] i_base,
    input  logic          i_neg,
    input  logic          i_undef,
    output logic          o_valid,
    output logic [CW-1:0] o_chroma,
    output logic [CW-1:0] o_vmax,
    output logic [HN-1:0] o_hnum,
    output logic [CW:0]   o_hrem,
    output logic [SN-1:0] o_snum,
    output logic [CW:0]   o_srem,
    output logic [HW-1:0] o_base,
    output logic          o_neg,
    output logic          o_undef
);
    import rhc_pkg::*;

    logic [CW+1:0] w_htry, w_stry;
    logic [CW:0]   n_hrem, n_srem;
    logic          w_hbit, w_sbit;

    // shift in the next dividend bit and try subtracting the divisor
    always_comb begin
        w_htry = {i_hrem, i_hnum[HN-1]} - {2'b00, i_chroma};
        w_stry = {i_srem, i_snum[SN-1]} - {2'b00, i_vmax};
        w_hbit = ~w_htry[CW+1];
        w_sbit = ~w_stry[CW+1];
        n_hrem = w_hbit ? w_htry[CW:0] : {i_hrem[CW-1:0], i_hnum[HN-1]};
        n_srem = w_sbit ? w_stry[CW:0] : {i_srem[CW-1:0], i_snum[SN-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_chroma <= i_chroma;
            o_vmax   <= i_vmax;
            o_hnum   <= {i_hnum[HN-2:0], w_hbit};
            o_hrem   <= n_hrem;
            o_snum   <= {i_snum[SN-2:0], w_sbit};
            o_srem   <= n_srem;
            o_base   <= i_base;
            o_neg    <= i_neg;
            o_undef  <= i_undef;
        end
    end
endmodule
